>>> rtl/mmnt_pkg.sv
// Shared constants, types and event codes of the mono note tracker.
package mmnt_pkg;

  localparam int NOTE_SLOTS = 128;
  localparam int SLOT_W     = $clog2(NOTE_SLOTS);
  localparam int NOTE_W     = 7;
  localparam int CNT_W      = 8;
  localparam int BYTE_W     = 8;
  localparam int CHAN_W     = 4;
  localparam int EV_W       = 2;
  localparam int KIND_W     = 4;

  localparam logic [EV_W-1:0] EV_NONE      = 2'd0;
  localparam logic [EV_W-1:0] EV_RETRIGGER = 2'd1;
  localparam logic [EV_W-1:0] EV_PITCH     = 2'd2;
  localparam logic [EV_W-1:0] EV_RELEASE   = 2'd3;

  localparam logic [KIND_W-1:0] KIND_NONE = 4'h0;
  localparam logic [KIND_W-1:0] KIND_OFF  = 4'h8;
  localparam logic [KIND_W-1:0] KIND_ON   = 4'h9;

  typedef struct packed {
    logic              exec;
    logic              note_on;
    logic [NOTE_W-1:0] note;
    logic              vel_zero;
  } cmd_t;

  typedef struct packed {
    logic [EV_W-1:0]   ev;
    logic [NOTE_W-1:0] note;
    logic [CNT_W-1:0]  total;
  } res_t;

endpackage

>>> rtl/mmnt_parser.sv
// MIDI byte parser that tracks the note message status and the first data byte.
module mmnt_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         acc,
  input  logic [mmnt_pkg::BYTE_W-1:0]  byte_in,
  input  logic [mmnt_pkg::CHAN_W-1:0]  listen,
  output mmnt_pkg::cmd_t               cmd
);

  logic [mmnt_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [mmnt_pkg::NOTE_W-1:0] first_r, first_nxt;
  logic                        have_r, have_nxt;
  logic                        is_note;

  assign is_note = (kind_r == mmnt_pkg::KIND_OFF) || (kind_r == mmnt_pkg::KIND_ON);

  always_comb begin
    kind_nxt  = kind_r;
    first_nxt = first_r;
    have_nxt  = have_r;
    if (acc) begin
      if (byte_in[7]) begin
        if (byte_in[3:0] == listen) begin
          kind_nxt = byte_in[7:4];
        end
      end else if (is_note) begin
        if (!have_r) begin
          first_nxt = byte_in[6:0];
          have_nxt  = 1'b1;
        end else begin
          kind_nxt = mmnt_pkg::KIND_NONE;
          have_nxt = 1'b0;
        end
      end else begin
        kind_nxt = mmnt_pkg::KIND_NONE;
      end
    end
  end

  always_comb begin
    cmd.exec     = !byte_in[7] && is_note && have_r;
    cmd.note_on  = (kind_r == mmnt_pkg::KIND_ON);
    cmd.note     = first_r;
    cmd.vel_zero = (byte_in[6:0] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= mmnt_pkg::KIND_NONE;
      first_r <= '0;
      have_r  <= 1'b0;
    end else begin
      kind_r  <= kind_nxt;
      first_r <= first_nxt;
      have_r  <= have_nxt;
    end
  end

endmodule

>>> rtl/mmnt_engine.sv
// Held-note map memory with the read-modify-write sequencer and downward scan.
module mmnt_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  mmnt_pkg::cmd_t  cmd,
  output logic            ready,
  output logic            res_valid,
  output mmnt_pkg::res_t  res,
  input  logic            res_take
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [mmnt_pkg::SLOT_W-1:0] LAST_SLOT =
    mmnt_pkg::SLOT_W'(mmnt_pkg::NOTE_SLOTS - 1);

  logic [2:0]                    state_r, state_nxt;
  logic [mmnt_pkg::CNT_W-1:0]    total_r, total_nxt, total_dec;
  logic [mmnt_pkg::NOTE_W-1:0]   cur_r, cur_nxt;
  logic [mmnt_pkg::EV_W-1:0]     ev_r, ev_nxt;
  logic [mmnt_pkg::NOTE_W-1:0]   op_note_r, op_note_nxt;
  logic                          op_on_r, op_on_nxt;
  logic [mmnt_pkg::SLOT_W-1:0]   scan_r, scan_nxt;
  logic [mmnt_pkg::SLOT_W-1:0]   clr_r, clr_nxt;
  logic [mmnt_pkg::SLOT_W-1:0]   op_idx;
  logic                          in_range;

  logic                          held_mem [mmnt_pkg::NOTE_SLOTS];
  logic                          rdata_r;
  logic                          we, wdata, re;
  logic [mmnt_pkg::SLOT_W-1:0]   waddr, raddr;

  assign op_idx    = op_note_r[mmnt_pkg::SLOT_W-1:0];
  assign in_range  = {1'b0, cmd.note} < (mmnt_pkg::NOTE_W + 1)'(mmnt_pkg::NOTE_SLOTS);
  assign total_dec = (total_r != '0) ? total_r - 1'b1 : total_r;

  always_comb begin
    state_nxt   = state_r;
    total_nxt   = total_r;
    cur_nxt     = cur_r;
    ev_nxt      = ev_r;
    op_note_nxt = op_note_r;
    op_on_nxt   = op_on_r;
    scan_nxt    = scan_r;
    clr_nxt     = clr_r;
    we          = 1'b0;
    wdata       = 1'b0;
    waddr       = '0;
    re          = 1'b0;
    raddr       = '0;
    unique case (state_r)
      ST_CLR: begin
        we      = 1'b1;
        waddr   = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          ev_nxt      = mmnt_pkg::EV_NONE;
          op_note_nxt = cmd.note;
          op_on_nxt   = cmd.note_on;
          if (cmd.exec && in_range && !(cmd.note_on && cmd.vel_zero)) begin
            re        = 1'b1;
            raddr     = cmd.note[mmnt_pkg::SLOT_W-1:0];
            state_nxt = ST_CHK;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_CHK: begin
        state_nxt = ST_DONE;
        if (op_on_r) begin
          if (!rdata_r) begin
            we     = 1'b1;
            wdata  = 1'b1;
            waddr  = op_idx;
            ev_nxt = (total_r == '0) ? mmnt_pkg::EV_RETRIGGER : mmnt_pkg::EV_PITCH;
            if (total_r < mmnt_pkg::CNT_W'(mmnt_pkg::NOTE_SLOTS)) begin
              total_nxt = total_r + 1'b1;
            end
            if (op_note_r >= cur_r) begin
              cur_nxt = op_note_r;
            end
          end
        end else if (rdata_r) begin
          we        = 1'b1;
          waddr     = op_idx;
          total_nxt = total_dec;
          if (total_dec == '0) begin
            cur_nxt = '0;
            ev_nxt  = mmnt_pkg::EV_RELEASE;
          end else if (op_note_r == cur_r) begin
            ev_nxt = mmnt_pkg::EV_PITCH;
            if (op_idx == '0) begin
              cur_nxt = '0;
            end else begin
              re        = 1'b1;
              raddr     = op_idx - 1'b1;
              scan_nxt  = op_idx - 1'b1;
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (rdata_r || scan_r == '0) begin
          cur_nxt   = mmnt_pkg::NOTE_W'(scan_r);
          state_nxt = ST_DONE;
        end else begin
          re       = 1'b1;
          raddr    = scan_r - 1'b1;
          scan_nxt = scan_r - 1'b1;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      held_mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= held_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      total_r <= '0;
      cur_r   <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      cur_r   <= cur_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_r      <= ev_nxt;
    op_note_r <= op_note_nxt;
    op_on_r   <= op_on_nxt;
    scan_r    <= scan_nxt;
  end

  assign ready     = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);

  always_comb begin
    res.ev    = ev_r;
    res.note  = cur_r;
    res.total = total_r;
  end

endmodule

>>> rtl/midi_mono_note_tracker.sv
// Top level of the monophonic MIDI note tracker with highest-note priority.
//
//   Channel  Direction  Handshake           Payload
//   in_      receive    in_valid/in_stall   in_byte_in
//   out_     send       out_valid/out_stall out_event_res, out_sounding_note, out_held_notes
//   cfg_     receive    cfg_valid/cfg_ready cfg_listen_channel
//
// A byte that does not touch the note map (this includes a note-on with velocity zero) goes
// straight from idle to the done state, a note message that reads the map also passes a check
// state, and a note-off of the sounding note with other notes still held adds a downward scan
// that reads one map entry per cycle through the single read port of the note map.
// After reset a clearing pass over all 128 note slots empties the note map while in_stall stays high.
// A finished result waits in the output register while the next byte is taken in.
module midi_mono_note_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mmnt_pkg::BYTE_W-1:0]   in_byte_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mmnt_pkg::EV_W-1:0]     out_event_res,
  output logic [mmnt_pkg::NOTE_W-1:0]   out_sounding_note,
  output logic [mmnt_pkg::CNT_W-1:0]    out_held_notes,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mmnt_pkg::CHAN_W-1:0]   cfg_listen_channel
);

  logic                          acc;
  logic                          eng_ready;
  logic                          res_valid;
  logic                          res_take;
  mmnt_pkg::cmd_t                cmd;
  mmnt_pkg::res_t                res;
  logic [mmnt_pkg::CHAN_W-1:0]   listen_r;
  logic                          out_valid_r;
  logic [mmnt_pkg::EV_W-1:0]     out_ev_r;
  logic [mmnt_pkg::NOTE_W-1:0]   out_note_r;
  logic [mmnt_pkg::CNT_W-1:0]    out_total_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = !eng_ready;
  assign acc       = in_valid && eng_ready;
  assign res_take  = res_valid && (!out_valid_r || !out_stall);

  mmnt_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .byte_in (in_byte_in),
    .listen  (listen_r),
    .cmd     (cmd)
  );

  mmnt_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .cmd       (cmd),
    .ready     (eng_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        listen_r <= cfg_listen_channel;
      end
      if (res_take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_ev_r    <= res.ev;
      out_note_r  <= res.note;
      out_total_r <= res.total;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = out_ev_r;
  assign out_sounding_note = out_note_r;
  assign out_held_notes    = out_total_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_held_notes <= mmnt_pkg::CNT_W'(mmnt_pkg::NOTE_SLOTS))
    else $error("Held note count exceeds the number of note slots.");

  a_release_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == mmnt_pkg::EV_RELEASE
      |-> out_held_notes == '0 && out_sounding_note == '0)
    else $error("Release event with notes still held.");

  a_retrigger_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == mmnt_pkg::EV_RETRIGGER |-> out_held_notes == 8'd1)
    else $error("Retrigger event without exactly one held note.");

  a_pitch_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == mmnt_pkg::EV_PITCH |-> out_held_notes != '0)
    else $error("Pitch update with no note held.");

  a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && out_valid_r && out_stall |=> res_valid)
    else $error("Finished result dropped while the output register was full.");

endmodule

>>> verif/tb_midi_mono_note_tracker.sv
// Self-checking testbench for the monophonic MIDI note tracker with highest-note priority.
module tb_midi_mono_note_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         PHASES        = 8;
  localparam int         PHASE_ITEMS   = 250;
  localparam int         SETTLE_CYCLES = 140;
  localparam int         LONG_HOLD     = 300;
  localparam int         IDLE_LIMIT    = 5000;
  localparam int         DIR_ROWS      = 26;

  typedef struct packed {
    logic [mmnt_pkg::BYTE_W-1:0] midi_byte;
    logic                        typed;
    mmnt_pkg::res_t              want;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [mmnt_pkg::BYTE_W-1:0]   in_byte_in;
  logic                          out_valid;
  logic                          out_stall;
  logic [mmnt_pkg::EV_W-1:0]     out_event_res;
  logic [mmnt_pkg::NOTE_W-1:0]   out_sounding_note;
  logic [mmnt_pkg::CNT_W-1:0]    out_held_notes;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [mmnt_pkg::CHAN_W-1:0]   cfg_listen_channel;

  bit                            note_held [mmnt_pkg::NOTE_SLOTS];
  logic [mmnt_pkg::CNT_W-1:0]    notes_down;
  logic [mmnt_pkg::NOTE_W-1:0]   top_note;
  logic [mmnt_pkg::KIND_W-1:0]   msg_kind;
  logic [mmnt_pkg::NOTE_W-1:0]   msg_note;
  bit                            msg_note_seen;
  logic [mmnt_pkg::CHAN_W-1:0]   listen_chan;

  mmnt_pkg::res_t                pending_results [$];
  mmnt_pkg::res_t                oldest;
  int                            mismatches = 0;
  int                            idle_cycles = 0;
  int                            phase_items;
  bit                            tx_quiet = 1'b0;
  bit                            rx_quiet = 1'b0;
  bit                            hold_req = 1'b0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{8'h00, 1'b1, {mmnt_pkg::EV_NONE,      7'd0,   8'd0}},
    '{8'h90, 1'b1, {mmnt_pkg::EV_NONE,      7'd0,   8'd0}},
    '{8'h7F, 1'b1, {mmnt_pkg::EV_NONE,      7'd0,   8'd0}},
    '{8'h7F, 1'b1, {mmnt_pkg::EV_RETRIGGER, 7'd127, 8'd1}},
    '{8'h90, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h01, 1'b1, {mmnt_pkg::EV_PITCH,     7'd127, 8'd2}},
    '{8'h90, 1'b0, '0},
    '{8'h3C, 1'b0, '0},
    '{8'h00, 1'b1, {mmnt_pkg::EV_NONE,      7'd127, 8'd2}},
    '{8'h90, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h55, 1'b1, {mmnt_pkg::EV_NONE,      7'd127, 8'd2}},
    '{8'h8F, 1'b1, {mmnt_pkg::EV_NONE,      7'd127, 8'd2}},
    '{8'h80, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'h40, 1'b1, {mmnt_pkg::EV_PITCH,     7'd0,   8'd1}},
    '{8'h80, 1'b0, '0},
    '{8'h05, 1'b0, '0},
    '{8'h00, 1'b1, {mmnt_pkg::EV_NONE,      7'd0,   8'd1}},
    '{8'hF0, 1'b0, '0},
    '{8'h12, 1'b1, {mmnt_pkg::EV_NONE,      7'd0,   8'd1}},
    '{8'h80, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h7F, 1'b1, {mmnt_pkg::EV_RELEASE,   7'd0,   8'd0}},
    '{8'hFF, 1'b0, '0}
  };

  midi_mono_note_tracker dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte_in         (in_byte_in),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_res      (out_event_res),
    .out_sounding_note  (out_sounding_note),
    .out_held_notes     (out_held_notes),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_listen_channel (cfg_listen_channel)
  );

  always #10 clk = ~clk;

  function automatic void clear_tracker();
    for (int i = 0; i < mmnt_pkg::NOTE_SLOTS; i++) note_held[i] = 1'b0;
  endfunction

  function automatic logic [mmnt_pkg::EV_W-1:0] press_note(logic [mmnt_pkg::NOTE_W-1:0] n,
                                                           logic [6:0] vel);
    logic [mmnt_pkg::EV_W-1:0] ev;
    if (vel == 7'd0 || note_held[n]) return mmnt_pkg::EV_NONE;
    note_held[n] = 1'b1;
    ev = (notes_down == 0) ? mmnt_pkg::EV_RETRIGGER : mmnt_pkg::EV_PITCH;
    if (notes_down < mmnt_pkg::NOTE_SLOTS) notes_down = notes_down + 1'b1;
    if (n >= top_note) top_note = n;
    return ev;
  endfunction

  function automatic logic [mmnt_pkg::EV_W-1:0] lift_note(logic [mmnt_pkg::NOTE_W-1:0] n);
    logic [mmnt_pkg::NOTE_W-1:0] scan;
    if (!note_held[n]) return mmnt_pkg::EV_NONE;
    note_held[n] = 1'b0;
    if (notes_down > 0) notes_down = notes_down - 1'b1;
    if (notes_down != 0) begin
      if (n != top_note) return mmnt_pkg::EV_NONE;
      scan = n;
      while (scan > 0 && !note_held[scan]) scan = scan - 1'b1;
      top_note = scan;
      return mmnt_pkg::EV_PITCH;
    end
    top_note = '0;
    clear_tracker();
    return mmnt_pkg::EV_RELEASE;
  endfunction

  function automatic mmnt_pkg::res_t track_byte(logic [mmnt_pkg::BYTE_W-1:0] b);
    logic [mmnt_pkg::EV_W-1:0] ev;
    ev = mmnt_pkg::EV_NONE;
    if (b[7]) begin
      if (b[3:0] == listen_chan) msg_kind = b[7:4];
    end else if (msg_kind == mmnt_pkg::KIND_OFF || msg_kind == mmnt_pkg::KIND_ON) begin
      if (!msg_note_seen) begin
        msg_note = b[6:0];
        msg_note_seen = 1'b1;
      end else begin
        if (msg_kind == mmnt_pkg::KIND_ON) ev = press_note(msg_note, b[6:0]);
        else ev = lift_note(msg_note);
        msg_kind = mmnt_pkg::KIND_NONE;
        msg_note_seen = 1'b0;
      end
    end else begin
      msg_kind = mmnt_pkg::KIND_NONE;
    end
    return {ev, top_note, notes_down};
  endfunction

  task automatic send_byte(input logic [mmnt_pkg::BYTE_W-1:0] b, input bit typed = 1'b0,
                           input mmnt_pkg::res_t want = '0);
    int gap;
    mmnt_pkg::res_t got;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte_in <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    got = track_byte(b);
    pending_results.push_back(typed ? want : got);
    phase_items++;
  endtask

  task automatic send_random_msg(input int note_lo, input int note_hi);
    int pick;
    logic [mmnt_pkg::NOTE_W-1:0] n;
    logic [6:0] vel;
    pick = $urandom_range(0, 99);
    n    = mmnt_pkg::NOTE_W'($urandom_range(note_lo, note_hi));
    vel  = ($urandom_range(0, 7) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
    if (pick < 65) begin
      send_byte({($urandom_range(0, 99) < 55) ? mmnt_pkg::KIND_ON : mmnt_pkg::KIND_OFF,
                 listen_chan});
      send_byte({1'b0, n});
      send_byte({1'b0, vel});
    end else if (pick < 75) begin
      send_byte({$urandom_range(0, 1) ? mmnt_pkg::KIND_ON : mmnt_pkg::KIND_OFF, listen_chan});
      send_byte({1'b0, n});
    end else if (pick < 83) begin
      send_byte({1'b1, 3'($urandom_range(0, 7)), 4'(listen_chan + $urandom_range(1, 15))});
      send_byte({1'b0, n});
    end else if (pick < 90) begin
      send_byte({4'($urandom_range(10, 15)), listen_chan});
      send_byte({1'b0, n});
    end else begin
      send_byte(8'($urandom));
    end
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_channel(input logic [mmnt_pkg::CHAN_W-1:0] ch);
    cfg_valid          <= 1'b1;
    cfg_listen_channel <= ch;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    listen_chan = ch;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int stall;
    out_stall = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = rx_quiet ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_stall <= 1'b1;
        repeat (stall) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result with no request waiting");
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_event_res !== oldest.ev) begin
          $error("event_res: expected %0d, got %0d", oldest.ev, out_event_res);
          mismatches++;
        end
        if (out_sounding_note !== oldest.note) begin
          $error("sounding_note: expected %0d, got %0d", oldest.note, out_sounding_note);
          mismatches++;
        end
        if (out_held_notes !== oldest.total) begin
          $error("held_notes: expected %0d, got %0d", oldest.total, out_held_notes);
          mismatches++;
        end
      end
    end
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0)
        || (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int lo;
    int hi;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_byte_in         = '0;
    cfg_valid          = 1'b0;
    cfg_listen_channel = '0;
    clear_tracker();
    notes_down    = '0;
    top_note      = '0;
    msg_kind      = mmnt_pkg::KIND_NONE;
    msg_note      = '0;
    msg_note_seen = 1'b0;
    listen_chan   = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    phase_items = 0;
    foreach (dir_tab[i]) send_byte(dir_tab[i].midi_byte, dir_tab[i].typed, dir_tab[i].want);
    in_valid <= 1'b0;
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 1) write_channel(4'd15);
      else if (p == 2) write_channel(4'd0);
      else if (p > 2) write_channel(4'($urandom_range(0, 15)));
      tx_quiet    = (p == 4) || ($urandom_range(0, 3) == 0);
      rx_quiet    = (p == 4) || (p == 5);
      hold_req    = (p == 2);
      phase_items = 0;
      if (p == 3) begin
        for (int n = 0; n < mmnt_pkg::NOTE_SLOTS; n++) begin
          send_byte({mmnt_pkg::KIND_ON, listen_chan});
          send_byte(8'(n));
          send_byte({1'b0, 7'($urandom_range(1, 127))});
        end
      end
      while (phase_items < PHASE_ITEMS) begin
        if (p % 2 == 0) begin
          lo = 0;
          hi = mmnt_pkg::NOTE_SLOTS - 1;
        end else begin
          lo = $urandom_range(0, mmnt_pkg::NOTE_SLOTS - 16);
          hi = lo + 15;
        end
        send_random_msg(lo, hi);
      end
      in_valid <= 1'b0;
      drain_results();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> midi_mono_note_tracker.f
rtl/mmnt_pkg.sv
rtl/mmnt_parser.sv
rtl/mmnt_engine.sv
rtl/midi_mono_note_tracker.sv
verif/tb_midi_mono_note_tracker.sv
